/* hw/rtl/okxc_pkg.sv */
// ----------------------------------------------------------------------------
// Offset-keyed XOR cipher package
// Shared widths, constants, item kinds and payload types for the cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none

package okxc_pkg;

   localparam int OFF_W      = 48;
   localparam int BYTE_W     = 8;
   localparam int SLOT_W     = 9;
   localparam int MOD_W      = 10;
   localparam int CHUNK_W    = 15;
   localparam int SUM_W      = CHUNK_W + 2;
   localparam int SQ_W       = 2 * CHUNK_W;
   localparam int DVD_W      = 32;
   localparam int STEP_BITS  = 2;
   localparam int CELL_COUNT = DVD_W / STEP_BITS;
   localparam int RSP_DEPTH  = 32;
   localparam int PTR_W      = $clog2(RSP_DEPTH);
   localparam int CNT_W      = PTR_W + 1;

   localparam logic [CHUNK_W-1:0] OFF_MOD  = 15'h7FFF;
   localparam logic [DVD_W-1:0]   IDX_BIAS = 32'd71214;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_DATA = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [SLOT_W-1:0]   key_slot;
      logic [BYTE_W-1:0]   value_byte;
      logic [OFF_W-1:0]    byte_offset;
      logic                last_in_buffer;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   result_byte;
      logic                result_last;
   } rsp_payload_type;

   typedef logic [MOD_W-1:0] csr_payload_type;

   typedef struct packed {
      kind_type            kind;
      logic [SLOT_W-1:0]   key_slot;
      logic [BYTE_W-1:0]   value_byte;
      logic                last_in_buffer;
      logic [DVD_W-1:0]    dvd;
      logic [MOD_W-1:0]    rem;
   } lane_type;

endpackage

`default_nettype wire

/* hw/rtl/okxc_chan_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready channel
// One item moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface okxc_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* hw/rtl/offset_keyed_table_xor_cipher_unit.sv */
// ----------------------------------------------------------------------------
// Offset-keyed table XOR cipher unit
// Loads key bytes and ciphers data bytes by a key byte chosen from the offset.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle unless the input stalls. Every item,
// load or data, runs through a fixed pipeline: registered reduce and square
// stages handle the offset, a chain of sixteen cells reduces the index modulo
// the key length two bits per cell, the key store is then read or written, and
// the key byte from its registered read is mixed into the data. Results wait
// in a 32-entry queue, and the input stalls only while 32 data items are
// accepted but not yet delivered. Loads travel the same pipeline, so a data
// item always sees every earlier load. Key store entries hold no defined value
// until loaded, and there is no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module offset_keyed_table_xor_cipher_unit #(
   parameter int KEY_DEPTH = 512
) (
   input  logic         clock,
   input  logic         reset,
   okxc_chan_if.sink    req_ch,
   okxc_chan_if.source  rsp_ch,
   okxc_chan_if.sink    csr_ch
);

   localparam int ADDR_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

   logic [okxc_pkg::MOD_W-1:0] modulus_ff;
   logic [okxc_pkg::MOD_W-1:0] modulus_in;
   logic [okxc_pkg::CNT_W-1:0] cnt_ff;
   logic [okxc_pkg::CNT_W-1:0] cnt_in;
   logic                       req_take;
   logic                       data_take;
   logic                       rsp_take;
   logic                       csr_take;

   logic                       chain_valid [okxc_pkg::CELL_COUNT+1];
   okxc_pkg::lane_type         chain_lane  [okxc_pkg::CELL_COUNT+1];
   logic                       tail_valid;
   okxc_pkg::lane_type         tail_lane;

   logic [ADDR_W+okxc_pkg::SLOT_W-1:0] slot_ext;
   logic [ADDR_W+okxc_pkg::MOD_W-1:0]  rem_ext;
   logic                               ram_we;
   logic [ADDR_W-1:0]                  ram_wr_addr;
   logic [ADDR_W-1:0]                  ram_rd_addr;
   logic [okxc_pkg::BYTE_W-1:0]        key_byte;

   logic                        rd_valid_ff;
   logic [okxc_pkg::BYTE_W-1:0] rd_value_ff;
   logic                        rd_last_ff;
   logic [2:0]                  rd_sel_ff;
   logic [2:0]                  shift;
   logic [okxc_pkg::BYTE_W-1:0] mixed;
   okxc_pkg::rsp_payload_type   result;

   assign csr_ch.ready = 1'b1;
   assign csr_take     = csr_ch.valid && csr_ch.ready;
   assign req_ch.ready = (cnt_ff < okxc_pkg::CNT_W'(okxc_pkg::RSP_DEPTH));
   assign req_take     = req_ch.valid && req_ch.ready;
   assign data_take    = req_take && (req_ch.payload.kind == okxc_pkg::KIND_DATA);
   assign rsp_take     = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      modulus_in = modulus_ff;
      if (csr_take) begin
         if (csr_ch.payload == '0) begin
            modulus_in = okxc_pkg::MOD_W'(1);
         end else if (32'(csr_ch.payload) > 32'(KEY_DEPTH)) begin
            modulus_in = okxc_pkg::MOD_W'(KEY_DEPTH);
         end else begin
            modulus_in = csr_ch.payload;
         end
      end
   end

   always_comb begin
      case ({data_take, rsp_take})
         2'b10:   cnt_in = cnt_ff + okxc_pkg::CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - okxc_pkg::CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= okxc_pkg::MOD_W'(1);
         cnt_ff     <= '0;
      end else begin
         modulus_ff <= modulus_in;
         cnt_ff     <= cnt_in;
      end
   end

   okxc_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_take),
      .up_item  (req_ch.payload),
      .dn_valid (chain_valid[0]),
      .dn_lane  (chain_lane[0])
   );

   for (genvar g = 0; g < okxc_pkg::CELL_COUNT; g++) begin : g_cell
      okxc_mod_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .modulus  (modulus_ff),
         .up_valid (chain_valid[g]),
         .up_lane  (chain_lane[g]),
         .dn_valid (chain_valid[g+1]),
         .dn_lane  (chain_lane[g+1])
      );
   end

   assign tail_valid  = chain_valid[okxc_pkg::CELL_COUNT];
   assign tail_lane   = chain_lane[okxc_pkg::CELL_COUNT];
   assign slot_ext    = {{ADDR_W{1'b0}}, tail_lane.key_slot};
   assign rem_ext     = {{ADDR_W{1'b0}}, tail_lane.rem};
   assign ram_wr_addr = slot_ext[ADDR_W-1:0];
   assign ram_rd_addr = rem_ext[ADDR_W-1:0];
   assign ram_we      = tail_valid && (tail_lane.kind == okxc_pkg::KIND_LOAD)
                     && (32'(tail_lane.key_slot) < 32'(KEY_DEPTH));

   okxc_ram #(
      .WIDTH (okxc_pkg::BYTE_W),
      .DEPTH (KEY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (tail_lane.value_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (key_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= tail_valid && (tail_lane.kind == okxc_pkg::KIND_DATA);
      end
      rd_value_ff <= tail_lane.value_byte;
      rd_last_ff  <= tail_lane.last_in_buffer;
      rd_sel_ff   <= tail_lane.rem[2:0];
   end

   // The published mix ORs a left and a right shift by the same amount.
   always_comb begin
      shift              = rd_sel_ff ^ 3'b100;
      mixed              = (key_byte << shift) | (key_byte >> shift);
      result.result_byte = rd_value_ff ^ mixed;
      result.result_last = rd_last_ff;
   end

   okxc_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (rd_valid_ff),
      .wr_data  (result),
      .rd_valid (rsp_ch.valid),
      .rd_ready (rsp_ch.ready),
      .rd_data  (rsp_ch.payload)
   );

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= okxc_pkg::CNT_W'(okxc_pkg::RSP_DEPTH))
      else $error("Outstanding data item count exceeds the result queue depth.");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (cnt_ff != '0))
      else $error("A result item is offered with no data item outstanding.");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (tail_valid && (tail_lane.kind == okxc_pkg::KIND_DATA)) |-> (tail_lane.rem < modulus_ff))
      else $error("Key index leaves the cell chain at or above the key length.");

   a_modulus_set: assert property (@(posedge clock) disable iff (reset)
      csr_take |=> ((modulus_ff != '0) && (32'(modulus_ff) <= 32'(KEY_DEPTH))))
      else $error("Key length register holds an unusable modulus after a write.");

endmodule

`default_nettype wire

/* hw/rtl/okxc_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module okxc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/okxc_prep.sv */
// ----------------------------------------------------------------------------
// Offset preparation stages
// Reduces offsets over 0x7FFF modulo 0x7FFF, squares, and adds the index bias.
// ----------------------------------------------------------------------------
`default_nettype none

module okxc_prep (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     up_valid,
   input  okxc_pkg::req_payload_type up_item,
   output logic                     dn_valid,
   output okxc_pkg::lane_type       dn_lane
);

   logic [okxc_pkg::SUM_W-1:0]     chunk_sum;
   logic [okxc_pkg::CHUNK_W:0]     fold_sum;
   logic [okxc_pkg::CHUNK_W:0]     fold_red;
   logic [okxc_pkg::CHUNK_W-1:0]   reduced;
   logic [okxc_pkg::SQ_W-1:0]      square;

   logic                           s1_valid_ff;
   okxc_pkg::lane_type             s1_lane_ff;
   okxc_pkg::lane_type             s1_lane_in;
   logic                           s2_valid_ff;
   okxc_pkg::lane_type             s2_lane_ff;
   okxc_pkg::lane_type             s2_lane_in;

   // Since 2^15 is one modulo 0x7FFF, summing 15-bit chunks keeps the residue.
   always_comb begin
      chunk_sum = okxc_pkg::SUM_W'(up_item.byte_offset[okxc_pkg::CHUNK_W-1:0])
                + okxc_pkg::SUM_W'(up_item.byte_offset[2*okxc_pkg::CHUNK_W-1:okxc_pkg::CHUNK_W])
                + okxc_pkg::SUM_W'(up_item.byte_offset[3*okxc_pkg::CHUNK_W-1:2*okxc_pkg::CHUNK_W])
                + okxc_pkg::SUM_W'(up_item.byte_offset[okxc_pkg::OFF_W-1:3*okxc_pkg::CHUNK_W]);
      fold_sum  = (okxc_pkg::CHUNK_W+1)'(chunk_sum[okxc_pkg::CHUNK_W-1:0])
                + (okxc_pkg::CHUNK_W+1)'(chunk_sum[okxc_pkg::SUM_W-1:okxc_pkg::CHUNK_W]);
      if (fold_sum >= {1'b0, okxc_pkg::OFF_MOD}) begin
         fold_red = fold_sum - {1'b0, okxc_pkg::OFF_MOD};
      end else begin
         fold_red = fold_sum;
      end
      if (|up_item.byte_offset[okxc_pkg::OFF_W-1:okxc_pkg::CHUNK_W]) begin
         reduced = fold_red[okxc_pkg::CHUNK_W-1:0];
      end else begin
         reduced = up_item.byte_offset[okxc_pkg::CHUNK_W-1:0];
      end

      s1_lane_in.kind           = up_item.kind;
      s1_lane_in.key_slot       = up_item.key_slot;
      s1_lane_in.value_byte     = up_item.value_byte;
      s1_lane_in.last_in_buffer = up_item.last_in_buffer;
      s1_lane_in.dvd            = okxc_pkg::DVD_W'(reduced);
      s1_lane_in.rem            = '0;
   end

   always_comb begin
      square     = s1_lane_ff.dvd[okxc_pkg::CHUNK_W-1:0] * s1_lane_ff.dvd[okxc_pkg::CHUNK_W-1:0];
      s2_lane_in = s1_lane_ff;
      s2_lane_in.dvd = okxc_pkg::DVD_W'(square) + okxc_pkg::IDX_BIAS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= up_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_lane_ff <= s1_lane_in;
      s2_lane_ff <= s2_lane_in;
   end

   assign dn_valid = s2_valid_ff;
   assign dn_lane  = s2_lane_ff;

endmodule

`default_nettype wire

/* hw/rtl/okxc_mod_cell.sv */
// ----------------------------------------------------------------------------
// Modulo reduction cell
// Shifts two dividend bits into the partial remainder, one restoring step each.
// ----------------------------------------------------------------------------
`default_nettype none

module okxc_mod_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [okxc_pkg::MOD_W-1:0] modulus,
   input  logic                       up_valid,
   input  okxc_pkg::lane_type         up_lane,
   output logic                       dn_valid,
   output okxc_pkg::lane_type         dn_lane
);

   logic                       valid_ff;
   okxc_pkg::lane_type         lane_ff;
   okxc_pkg::lane_type         lane_in;
   logic [okxc_pkg::MOD_W:0]   trial;
   logic [okxc_pkg::MOD_W-1:0] rem_v;
   logic [okxc_pkg::DVD_W-1:0] dvd_v;

   always_comb begin
      rem_v = up_lane.rem;
      dvd_v = up_lane.dvd;
      trial = '0;
      for (int i = 0; i < okxc_pkg::STEP_BITS; i++) begin
         trial = {rem_v, dvd_v[okxc_pkg::DVD_W-1]};
         dvd_v = dvd_v << 1;
         if (trial >= {1'b0, modulus}) begin
            trial = trial - {1'b0, modulus};
         end
         rem_v = trial[okxc_pkg::MOD_W-1:0];
      end
      lane_in     = up_lane;
      lane_in.dvd = dvd_v;
      lane_in.rem = rem_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
      lane_ff <= lane_in;
   end

   assign dn_valid = valid_ff;
   assign dn_lane  = lane_ff;

endmodule

`default_nettype wire

/* hw/rtl/okxc_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// Result queue
// Holds finished result items until the downstream side takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module okxc_rsp_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  okxc_pkg::rsp_payload_type wr_data,
   output logic                      rd_valid,
   input  logic                      rd_ready,
   output okxc_pkg::rsp_payload_type rd_data
);

   okxc_pkg::rsp_payload_type  mem_ff [okxc_pkg::RSP_DEPTH];
   logic [okxc_pkg::PTR_W-1:0] wr_ptr_ff;
   logic [okxc_pkg::PTR_W-1:0] rd_ptr_ff;
   logic [okxc_pkg::CNT_W-1:0] fill_ff;
   logic [okxc_pkg::CNT_W-1:0] fill_in;
   logic                       pop;

   assign rd_valid = (fill_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      case ({wr_en, pop})
         2'b10:   fill_in = fill_ff + okxc_pkg::CNT_W'(1);
         2'b01:   fill_in = fill_ff - okxc_pkg::CNT_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + okxc_pkg::PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + okxc_pkg::PTR_W'(1);
         end
         fill_ff <= fill_in;
      end
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

/* tb/offset_keyed_table_xor_cipher_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Offset-keyed table XOR cipher unit testbench
// Tests the reset key length, fills the key store, then sends key loads and
// data bytes under several key lengths with random gaps and stalls on both
// channels. A local copy of the key store and the key length predicts each
// ciphered byte at acceptance, and results are checked in order against them.
// ----------------------------------------------------------------------------

module offset_keyed_table_xor_cipher_unit_tb;

   localparam int          KEY_DEPTH     = 512;
   localparam int          KEY_AW        = $clog2(KEY_DEPTH);
   localparam int unsigned OFFSET_WRAP   = 'h7FFF;
   localparam int unsigned INDEX_BIAS    = 71214;
   localparam int          DRAIN_CYCLES  = 24;
   localparam int          HOLD_CYCLES   = 200;
   localparam int          CYCLE_LIMIT   = 1000000;
   localparam int          RANDOM_PHASES = 6;
   localparam int          PHASE_ITEMS   = 180;

   logic clock;
   logic reset;

   okxc_chan_if #(.payload_type(okxc_pkg::req_payload_type)) req_if ();
   okxc_chan_if #(.payload_type(okxc_pkg::rsp_payload_type)) rsp_if ();
   okxc_chan_if #(.payload_type(okxc_pkg::csr_payload_type)) csr_if ();

   offset_keyed_table_xor_cipher_unit #(
      .KEY_DEPTH(KEY_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_ch(csr_if)
   );

   logic [okxc_pkg::BYTE_W-1:0] key_table [KEY_DEPTH];
   okxc_pkg::csr_payload_type   key_length_q = okxc_pkg::MOD_W'(1);
   okxc_pkg::rsp_payload_type   pending_results [$];
   int                          error_count = 0;
   int                          cycle_count = 0;
   bit                          no_idle = 1'b0;
   bit                          hold_off_pending = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic okxc_pkg::rsp_payload_type cipher_byte(
         input okxc_pkg::req_payload_type item);
      longint unsigned           off;
      longint unsigned           modulus;
      longint unsigned           idx;
      logic [2:0]                shift;
      logic [7:0]                k;
      logic [7:0]                mixed;
      okxc_pkg::rsp_payload_type res;
      modulus = 64'(key_length_q);
      if (modulus == 64'd0) modulus = 64'd1;
      if (modulus > 64'(KEY_DEPTH)) modulus = 64'(KEY_DEPTH);
      off = 64'(item.byte_offset);
      if (off > 64'(OFFSET_WRAP)) off = off % 64'(OFFSET_WRAP);
      idx = (off * off + 64'(INDEX_BIAS)) % modulus;
      k = key_table[idx[KEY_AW-1:0]];
      shift = 3'((idx & 64'd7) + 64'd4);
      mixed = (k << shift) | (k >> shift);
      res.result_byte = item.value_byte ^ mixed;
      res.result_last = item.last_in_buffer;
      return res;
   endfunction

   function automatic logic [okxc_pkg::OFF_W-1:0] random_offset();
      logic [63:0]     wide;
      longint unsigned wraps;
      int              r;
      r = $urandom_range(0, 9);
      wide = {$urandom, $urandom};
      wraps = 64'($urandom);
      case (r)
         0: wide = 64'($urandom_range(0, 255));
         1: wide = 64'h7FF0 + 64'($urandom_range(0, 31));
         2: wide = wraps * 64'(OFFSET_WRAP) + 64'($urandom_range(0, 3));
         3: wide = 64'hFFFF_FFFF_FFFF - 64'($urandom_range(0, 255));
         default: ;
      endcase
      return wide[okxc_pkg::OFF_W-1:0];
   endfunction

   function automatic logic [okxc_pkg::OFF_W-1:0] edge_offset(input int i);
      case (i % 8)
         0: return 48'h0;
         1: return 48'h1;
         2: return 48'h7FFE;
         3: return 48'h7FFF;
         4: return 48'h8000;
         5: return 48'hFFFE;
         6: return 48'hFFFF;
         default: return 48'hFFFF_FFFF_FFFF;
      endcase
   endfunction

   function automatic okxc_pkg::req_payload_type make_data(
         input logic [okxc_pkg::OFF_W-1:0]  offset,
         input logic [okxc_pkg::BYTE_W-1:0] value,
         input logic                        last);
      okxc_pkg::req_payload_type item;
      item.kind           = okxc_pkg::KIND_DATA;
      item.key_slot       = okxc_pkg::SLOT_W'($urandom);
      item.value_byte     = value;
      item.byte_offset    = offset;
      item.last_in_buffer = last;
      return item;
   endfunction

   function automatic okxc_pkg::req_payload_type make_load(
         input logic [okxc_pkg::SLOT_W-1:0] slot,
         input logic [okxc_pkg::BYTE_W-1:0] value);
      okxc_pkg::req_payload_type item;
      item.kind           = okxc_pkg::KIND_LOAD;
      item.key_slot       = slot;
      item.value_byte     = value;
      item.byte_offset    = random_offset();
      item.last_in_buffer = 1'($urandom);
      return item;
   endfunction

   task automatic send_item(input okxc_pkg::req_payload_type item);
      int gap;
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      if (item.kind == okxc_pkg::KIND_LOAD) key_table[item.key_slot] = item.value_byte;
      else pending_results.push_back(cipher_byte(item));
      gap = gap_cycles();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_key_length(input okxc_pkg::csr_payload_type len);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= len;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      key_length_q = len;
   endtask

   task automatic send_random_item();
      if ($urandom_range(0, 3) == 0) begin
         send_item(make_load(okxc_pkg::SLOT_W'($urandom), okxc_pkg::BYTE_W'($urandom)));
      end else begin
         send_item(make_data(random_offset(), okxc_pkg::BYTE_W'($urandom), 1'($urandom)));
      end
   endtask

   // With the reset key length every data byte uses key entry zero.
   task automatic test_reset_key_length();
      send_item(make_load(okxc_pkg::SLOT_W'(0), 8'hA5));
      for (int i = 0; i < 8; i++) begin
         send_item(make_data(edge_offset(i), (i % 2 == 1) ? 8'hFF : 8'h00, 1'(i % 2)));
      end
      send_item(make_load(okxc_pkg::SLOT_W'(0), 8'h3C));
      send_item(make_data(48'h0, 8'h5A, 1'b1));
   endtask

   task automatic test_key_fill();
      for (int slot = 0; slot < KEY_DEPTH; slot++) begin
         send_item(make_load(okxc_pkg::SLOT_W'(slot), okxc_pkg::BYTE_W'($urandom)));
      end
   endtask

   task automatic test_key_length_limits();
      okxc_pkg::csr_payload_type len;
      for (int i = 0; i < 4; i++) begin
         case (i)
            0: len = 10'd0;
            1: len = 10'h3FF;
            2: len = 10'd513;
            default: len = 10'd512;
         endcase
         wait_idle();
         write_key_length(len);
         for (int j = 0; j < 3; j++) begin
            send_item(make_data(edge_offset(3 * i + j), okxc_pkg::BYTE_W'($urandom),
                                1'($urandom)));
         end
      end
   endtask

   task automatic test_random_traffic();
      okxc_pkg::csr_payload_type len;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: len = 10'd1;
            1: len = 10'd7;
            2: len = 10'd256;
            3: len = 10'd511;
            4: len = okxc_pkg::MOD_W'($urandom_range(1, 64));
            default: len = okxc_pkg::MOD_W'($urandom_range(0, 1023));
         endcase
         wait_idle();
         write_key_length(len);
         no_idle = (p == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
         no_idle = 1'b0;
      end
   endtask

   task automatic test_backpressure();
      wait_idle();
      write_key_length(10'd512);
      no_idle = 1'b1;
      hold_off_pending = 1'b1;
      for (int n = 0; n < 80; n++) begin
         send_item(make_data(random_offset(), okxc_pkg::BYTE_W'($urandom), 1'($urandom)));
      end
      no_idle = 1'b0;
      for (int n = 0; n < 40; n++) send_random_item();
      wait_idle();
      for (int n = 0; n < 40; n++) send_random_item();
   endtask

   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            rsp_if.ready <= 1'b0;
            hold_off_pending = 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            gap = gap_cycles();
            if (gap > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      okxc_pkg::rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual byte %h last %b",
                     $time, rsp_if.payload.result_byte, rsp_if.payload.result_last);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (want.result_byte !== rsp_if.payload.result_byte) begin
               $display("%0t: result_byte mismatch, expected %h, actual %h",
                        $time, want.result_byte, rsp_if.payload.result_byte);
               error_count++;
            end
            if (want.result_last !== rsp_if.payload.result_last) begin
               $display("%0t: result_last mismatch, expected %b, actual %b",
                        $time, want.result_last, rsp_if.payload.result_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("offset_keyed_table_xor_cipher_unit regression: fail");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.payload <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_key_length();
      test_key_fill();
      test_key_length_limits();
      test_random_traffic();
      test_backpressure();
      wait_idle();
      if (error_count == 0) begin
         $display("offset_keyed_table_xor_cipher_unit regression: pass");
      end else begin
         $display("offset_keyed_table_xor_cipher_unit regression: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/okxc_pkg.sv
hw/rtl/okxc_chan_if.sv
hw/rtl/okxc_ram.sv
hw/rtl/okxc_prep.sv
hw/rtl/okxc_mod_cell.sv
hw/rtl/okxc_rsp_fifo.sv
hw/rtl/offset_keyed_table_xor_cipher_unit.sv
tb/offset_keyed_table_xor_cipher_unit_tb.sv
